// ===== rtl/core/ottt_pkg.sv =====
// Package for the owner-tagged timer table: sizes, field widths, action and
// result codes, controller state type and the controller/datapath structs.
// No dependencies; every other file of the block imports it.
package ottt_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Field widths fixed by the interface.
  localparam int ACT_W   = 2;
  localparam int TIME_W  = 32;
  localparam int OWNER_W = 16;
  localparam int DELAY_W = 16;
  localparam int TAG_W   = 32;
  localparam int KIND_W  = 3;
  localparam int CNT_W   = 6;
  localparam int IVL_W   = 16;

  // Check interval after reset.
  localparam logic [IVL_W-1:0] INTERVAL_AT_RESET = 16'd5;

  // Action codes of an input item.
  localparam logic [ACT_W-1:0] ACT_CHECK  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CANCEL = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ADDED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCEL  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIRED   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DONE    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SKIPPED = 3'd5;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              accept;      // take the input item
    logic              scan;        // a table scan is in progress
    logic              advance;     // retire the current entry and step on
    logic              emit_final;  // load the closing result item
    logic [KIND_W-1:0] final_kind;
  } ottt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACT_W-1:0] in_action;     // action of the offered item
    logic             interval_pass; // offered check item may run
    logic             act_check;     // latched item is a check
    logic             act_add;       // latched item is an add
    logic             hit;           // current entry matches the action
    logic             last_entry;    // current entry is the last one
    logic             out_free;      // output register can take an item
  } ottt_sts_t;

endpackage

// ===== rtl/core/ottt_ctrl.sv =====
// Controller of the timer table: sequences accept, entry scan and the
// closing result. Depends on ottt_pkg; drives ottt_dp through ottt_cmd_t.
module ottt_ctrl
  import ottt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ottt_sts_t sts,
  output ottt_cmd_t cmd
);

  state_t            state_r, state_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;

  // State and pending result kind.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= KIND_ADDED;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  // New items are taken only while no item is in work.
  assign in_stall = (state_r != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    cmd            = '0;
    cmd.final_kind = kind_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (sts.in_action)
            ACT_CHECK: begin
              if (sts.interval_pass) begin
                state_nxt = ST_SCAN;
                kind_nxt  = KIND_DONE;
              end else begin
                state_nxt = ST_FINAL;
                kind_nxt  = KIND_SKIPPED;
              end
            end
            ACT_ADD: begin
              // Stays full unless a free entry turns up.
              state_nxt = ST_SCAN;
              kind_nxt  = KIND_FULL;
            end
            ACT_CANCEL: begin
              state_nxt = ST_SCAN;
              kind_nxt  = KIND_CANCEL;
            end
            default: begin
              // Unused code: item is dropped without a result.
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        // A firing entry waits until the output register is free.
        if (!(sts.hit && sts.act_check && !sts.out_free)) begin
          cmd.advance = 1'b1;
          if (sts.hit && sts.act_add) begin
            kind_nxt  = KIND_ADDED;
            state_nxt = ST_FINAL;
          end else if (sts.last_entry) begin
            state_nxt = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ottt_dp.sv =====
// Datapath of the timer table: slot memory, valid bits, scan index, count,
// last-check time, interval register and output register. Depends on ottt_pkg.
module ottt_dp
  import ottt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [IVL_W-1:0]          cfg_wr_data,
  input  logic [ACT_W-1:0]          in_action,
  input  logic [TIME_W-1:0]         in_current_time,
  input  logic [OWNER_W-1:0]        in_owner_id,
  input  logic [DELAY_W-1:0]        in_delay,
  input  logic signed [TAG_W-1:0]   in_event_tag,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [KIND_W-1:0]         out_kind,
  output logic [OWNER_W-1:0]        out_fired_owner,
  output logic signed [TAG_W-1:0]   out_fired_tag,
  output logic [CNT_W-1:0]          out_count,
  output logic                      out_last,
  input  ottt_cmd_t                 cmd,
  output ottt_sts_t                 sts
);

  localparam int ENTRY_W = OWNER_W + TAG_W + TIME_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Configuration and check bookkeeping.
  logic [IVL_W-1:0]   interval_r;
  logic [TIME_W-1:0]  last_check_r;

  // Latched input item.
  logic [ACT_W-1:0]   act_r;
  logic [TIME_W-1:0]  now_r;
  logic [OWNER_W-1:0] owner_r;
  logic [DELAY_W-1:0] delay_r;
  logic [TAG_W-1:0]   tag_r;

  // Scan state.
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   rd_addr;
  logic [CNT_W-1:0]   cnt_r;
  logic               valid_r [TABLE_ENTRIES];

  // Slot memory and its registered read port.
  logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [OWNER_W-1:0] ent_owner;
  logic [TAG_W-1:0]   ent_tag;
  logic [TIME_W-1:0]  ent_trigger;

  // Output register.
  logic               out_valid_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic [OWNER_W-1:0] out_owner_r;
  logic [TAG_W-1:0]   out_tag_r;
  logic [CNT_W-1:0]   out_count_r;
  logic               out_last_r;

  logic [TIME_W-1:0]  since_check;
  logic [TIME_W-1:0]  since_trigger;
  logic               ent_valid;
  logic               fired;
  logic               hit;
  logic               out_free;
  logic               wr_en;
  logic               fire_emit;

  assign {ent_owner, ent_tag, ent_trigger} = rd_data_r;

  // Interval test for an offered check item.
  assign since_check = in_current_time - last_check_r;

  // Match of the current entry against the latched action.
  assign ent_valid     = valid_r[idx_r];
  assign since_trigger = now_r - ent_trigger;
  assign fired         = (since_trigger != '0) && !since_trigger[TIME_W-1];

  always_comb begin
    unique case (act_r)
      ACT_CHECK:  hit = ent_valid && fired;
      ACT_ADD:    hit = !ent_valid;
      ACT_CANCEL: hit = ent_valid && (ent_owner == owner_r);
      default:    hit = 1'b0;
    endcase
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign wr_en     = cmd.advance && hit && (act_r == ACT_ADD);
  assign fire_emit = cmd.advance && hit && (act_r == ACT_CHECK);

  assign sts.in_action     = in_action;
  assign sts.interval_pass = (since_check > TIME_W'(interval_r));
  assign sts.act_check     = (act_r == ACT_CHECK);
  assign sts.act_add       = (act_r == ACT_ADD);
  assign sts.hit           = hit;
  assign sts.last_entry    = (idx_r == LAST_IDX);
  assign sts.out_free      = out_free;

  // Read address: the next entry on a step, the current one while held.
  always_comb begin
    if (cmd.advance) begin
      idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
      rd_addr = idx_nxt;
    end else if (cmd.scan) begin
      idx_nxt = idx_r;
      rd_addr = idx_r;
    end else begin
      idx_nxt = cmd.accept ? '0 : idx_r;
      rd_addr = '0;
    end
  end

  // Control registers: interval, last check, index, count, latched action, valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r   <= INTERVAL_AT_RESET;
      last_check_r <= '0;
      idx_r        <= '0;
      cnt_r        <= '0;
      act_r        <= ACT_CHECK;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_wr_en) begin
        interval_r <= cfg_wr_data;
      end
      idx_r <= idx_nxt;
      if (cmd.accept) begin
        act_r <= in_action;
        cnt_r <= '0;
        if ((in_action == ACT_CHECK) && sts.interval_pass) begin
          last_check_r <= in_current_time;
        end
      end
      if (cmd.advance && hit) begin
        if (act_r == ACT_ADD) begin
          valid_r[idx_r] <= 1'b1;
        end else begin
          valid_r[idx_r] <= 1'b0;
          cnt_r          <= cnt_r + 1'b1;
        end
      end
    end
  end

  // Payload of the latched item.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_r   <= in_current_time;
      owner_r <= in_owner_id;
      delay_r <= in_delay;
      tag_r   <= $unsigned(in_event_tag);
    end
  end

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= {owner_r, tag_r, now_r + TIME_W'(delay_r)};
    end
    rd_data_r <= mem[rd_addr];
  end

  // Output register: valid flag under reset, payload without.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire_emit || cmd.emit_final) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_emit) begin
      out_kind_r  <= KIND_FIRED;
      out_owner_r <= ent_owner;
      out_tag_r   <= ent_tag;
      out_count_r <= '0;
      out_last_r  <= 1'b0;
    end else if (cmd.emit_final) begin
      out_kind_r  <= cmd.final_kind;
      out_owner_r <= '0;
      out_tag_r   <= '0;
      out_count_r <= ((cmd.final_kind == KIND_CANCEL) || (cmd.final_kind == KIND_DONE))
                     ? cnt_r : '0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_fired_owner = out_owner_r;
  assign out_fired_tag   = $signed(out_tag_r);
  assign out_count       = out_count_r;
  assign out_last        = out_last_r;

endmodule

// ===== rtl/core/owner_tagged_timer_table_core.sv =====
// Owner-tagged timer table: a fixed table of one-shot timers with add,
// cancel-by-owner and periodic check. Top level joining ottt_ctrl and
// ottt_dp; depends on ottt_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one action item: check,
//   add or cancel, with the present time and the owner, delay and tag.
//   Result channel (out_valid / out_stall) carries result items; the last
//   result caused by an input item has out_last set. A check that runs
//   gives one fired item per expired timer, then a done item with the count.
//   cfg_wr_en / cfg_wr_data write the check interval; write only while idle.
// Timing:
//   One item at a time. An add scans entries from the lowest until it finds
//   a free one; check and cancel scan all TABLE_ENTRIES entries, one per
//   cycle through the single read port of the slot memory, unless a firing
//   entry waits for the result register. A fired item is loaded into the
//   result register when its entry is retired; a closing item is loaded in
//   the final state, once the register is free, after the scan or accept.
// Reset clears all valid bits, the last check time and sets the interval
// to 5. When the receiver stalls, the scan holds at a firing entry and the
// result register keeps its item until it is taken.
module owner_tagged_timer_table_core
  import ottt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [IVL_W-1:0]        cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [ACT_W-1:0]        in_action,
  input  logic [TIME_W-1:0]       in_current_time,
  input  logic [OWNER_W-1:0]      in_owner_id,
  input  logic [DELAY_W-1:0]      in_delay,
  input  logic signed [TAG_W-1:0] in_event_tag,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [KIND_W-1:0]       out_kind,
  output logic [OWNER_W-1:0]      out_fired_owner,
  output logic signed [TAG_W-1:0] out_fired_tag,
  output logic [CNT_W-1:0]        out_count,
  output logic                    out_last
);

  ottt_cmd_t cmd;
  ottt_sts_t sts;

  // Sequencer.
  ottt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table storage and result path.
  ottt_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_action       (in_action),
    .in_current_time (in_current_time),
    .in_owner_id     (in_owner_id),
    .in_delay        (in_delay),
    .in_event_tag    (in_event_tag),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_fired_owner (out_fired_owner),
    .out_fired_tag   (out_fired_tag),
    .out_count       (out_count),
    .out_last        (out_last),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for owner_tagged_timer_table_core: directed, table-full
// and random add/cancel/check items, checked against an in-bench timer table model.
// Depends on ottt_pkg and the owner_tagged_timer_table_core RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ottt_pkg::*;

  // Action code that the block ignores.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  // Cycles a full table scan may still take after the last result.
  localparam int LATENCY_CYCLES = TABLE_ENTRIES + 8;
  localparam int DRAIN_LIMIT = 20000;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic [KIND_W-1:0]       kind;
    logic [OWNER_W-1:0]      owner;
    logic signed [TAG_W-1:0] tag;
    logic [CNT_W-1:0]        count;
    logic                    final_flag;
  } timer_result_t;

  // Clock, reset and block ports.
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_wr_en = 1'b0;
  logic [IVL_W-1:0]        cfg_wr_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [ACT_W-1:0]        in_action = '0;
  logic [TIME_W-1:0]       in_current_time = '0;
  logic [OWNER_W-1:0]      in_owner_id = '0;
  logic [DELAY_W-1:0]      in_delay = '0;
  logic signed [TAG_W-1:0] in_event_tag = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [KIND_W-1:0]       out_kind;
  logic [OWNER_W-1:0]      out_fired_owner;
  logic signed [TAG_W-1:0] out_fired_tag;
  logic [CNT_W-1:0]        out_count;
  logic                    out_last;

  // Timer table as the bench expects it.
  bit                      tmr_live [TABLE_ENTRIES];
  logic [OWNER_W-1:0]      tmr_owner [TABLE_ENTRIES];
  logic signed [TAG_W-1:0] tmr_tag [TABLE_ENTRIES];
  logic [TIME_W-1:0]       tmr_due [TABLE_ENTRIES];
  logic [TIME_W-1:0]       last_scan_time = '0;
  logic [IVL_W-1:0]        scan_interval = INTERVAL_AT_RESET;

  timer_result_t pending_results [$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int fired_total = 0;
  int full_total = 0;
  int skipped_total = 0;
  int send_idle_pct = 35;
  int recv_idle_pct = 66;
  int holdoff_left = 0;
  logic [TIME_W-1:0] sim_now = '0;

  owner_tagged_timer_table_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_current_time (in_current_time),
    .in_owner_id     (in_owner_id),
    .in_delay        (in_delay),
    .in_event_tag    (in_event_tag),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_fired_owner (out_fired_owner),
    .out_fired_tag   (out_fired_tag),
    .out_count       (out_count),
    .out_last        (out_last)
  );

  initial forever #1 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #1_000_000;
    $display("owner_tagged_timer_table_core test failed");
    $finish;
  end

  function automatic void expect_result(logic [KIND_W-1:0] kind, logic [OWNER_W-1:0] owner,
                                        logic signed [TAG_W-1:0] tag, logic [CNT_W-1:0] count,
                                        logic final_flag);
    timer_result_t r;
    r.kind = kind;
    r.owner = owner;
    r.tag = tag;
    r.count = count;
    r.final_flag = final_flag;
    pending_results.push_back(r);
  endfunction

  // Updates the expected table for one accepted item and queues its results.
  function automatic void predict_timer_item(logic [ACT_W-1:0] action, logic [TIME_W-1:0] now,
                                             logic [OWNER_W-1:0] owner,
                                             logic [DELAY_W-1:0] delay,
                                             logic signed [TAG_W-1:0] tag);
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] since_scan;
    logic [CNT_W-1:0]  hits;
    bit                placed;
    hits = '0;
    placed = 1'b0;
    case (action)
      ACT_CHECK: begin
        since_scan = now - last_scan_time;
        if (since_scan <= {{(TIME_W-IVL_W){1'b0}}, scan_interval}) begin
          expect_result(KIND_SKIPPED, '0, '0, '0, 1'b1);
          skipped_total++;
        end else begin
          last_scan_time = now;
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            age = now - tmr_due[i];
            // Fires only when strictly later, within half the time range.
            if (tmr_live[i] && age != '0 && !age[TIME_W-1]) begin
              expect_result(KIND_FIRED, tmr_owner[i], tmr_tag[i], '0, 1'b0);
              tmr_live[i] = 1'b0;
              hits++;
              fired_total++;
            end
          end
          expect_result(KIND_DONE, '0, '0, hits, 1'b1);
        end
      end
      ACT_ADD: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!placed && !tmr_live[i]) begin
            tmr_live[i] = 1'b1;
            tmr_owner[i] = owner;
            tmr_tag[i] = tag;
            tmr_due[i] = now + {{(TIME_W-DELAY_W){1'b0}}, delay};
            placed = 1'b1;
          end
        end
        if (placed) begin
          expect_result(KIND_ADDED, '0, '0, '0, 1'b1);
        end else begin
          expect_result(KIND_FULL, '0, '0, '0, 1'b1);
          full_total++;
        end
      end
      ACT_CANCEL: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (tmr_live[i] && tmr_owner[i] == owner) begin
            tmr_live[i] = 1'b0;
            hits++;
          end
        end
        expect_result(KIND_CANCEL, '0, '0, hits, 1'b1);
      end
      default: begin
        // Unused code: nothing changes and nothing comes back.
      end
    endcase
  endfunction

  function automatic int count_free_slots();
    int n;
    n = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!tmr_live[i]) n++;
    end
    return n;
  endfunction

  function automatic void report_mismatch(string field, logic [31:0] exp_val,
                                          logic [31:0] act_val);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, act_val);
    end
  endfunction

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left = holdoff_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result checker. Values are sampled mid-cycle, where they are settled; the
  // item is taken at the next rising edge.
  always @(negedge clk) begin
    timer_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", '0, 32'(out_kind));
      end else begin
        exp_r = pending_results.pop_front();
        if (out_kind !== exp_r.kind)
          report_mismatch("kind", 32'(exp_r.kind), 32'(out_kind));
        if (out_fired_owner !== exp_r.owner)
          report_mismatch("fired_owner", 32'(exp_r.owner), 32'(out_fired_owner));
        if (out_fired_tag !== exp_r.tag) report_mismatch("fired_tag", exp_r.tag, out_fired_tag);
        if (out_count !== exp_r.count)
          report_mismatch("count", 32'(exp_r.count), 32'(out_count));
        if (out_last !== exp_r.final_flag)
          report_mismatch("last", 32'(exp_r.final_flag), 32'(out_last));
      end
    end
  end

  // Offers one item and returns at the edge where it is taken, valid still high.
  task automatic send_item(input logic [ACT_W-1:0] action, input logic [TIME_W-1:0] now,
                           input logic [OWNER_W-1:0] owner, input logic [DELAY_W-1:0] delay,
                           input logic signed [TAG_W-1:0] tag);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_current_time <= now;
    in_owner_id <= owner;
    in_delay <= delay;
    in_event_tag <= tag;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    items_sent++;
    predict_timer_item(action, now, owner, delay, tag);
  endtask

  // Stops sending and waits until every expected result is in and the block is idle.
  task automatic wait_for_drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input logic [IVL_W-1:0] value);
    wait_for_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    scan_interval = value;
  endtask

  // Every action, field extremes, the interval boundary and an empty cancel.
  task automatic test_basic_actions();
    send_item(ACT_CHECK, 32'd3, '0, '0, '0);
    send_item(ACT_CHECK, 32'd5, '0, '0, '0);
    send_item(ACT_CHECK, 32'd6, '0, '0, '0);
    send_item(ACT_CANCEL, 32'd6, 16'h1234, '0, '0);
    send_item(ACT_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, -32'sd1);
    send_item(ACT_ADD, 32'd10, 16'hFFFF, 16'd0, 32'sh7FFF_FFFF);
    send_item(ACT_ADD, 32'd10, 16'h0000, 16'hFFFF, 32'sh8000_0000);
    send_item(ACT_ADD, 32'd10, 16'hA5A5, 16'd1, -32'sd1);
    send_item(ACT_CHECK, 32'd10, '0, '0, '0);
    send_item(ACT_CHECK, 32'd20, '0, '0, '0);
    send_item(ACT_CANCEL, 32'd20, 16'h0000, '0, '0);
    send_item(ACT_CANCEL, 32'd20, 16'hFFFF, '0, '0);
  endtask

  // Trigger times and the interval test across the 32-bit wrap, and the
  // half-range limit of the "later than" comparison.
  task automatic test_time_wrap();
    write_interval(16'd0);
    send_item(ACT_ADD, 32'hFFFF_FFF0, 16'h0F0F, 16'h0020, 32'sh1234_5678);
    send_item(ACT_ADD, 32'hFFFF_FFF0, 16'hF0F0, 16'h0000, 32'shDEAD_BEEF);
    send_item(ACT_CHECK, 32'hFFFF_FFF0, '0, '0, '0);
    send_item(ACT_CHECK, 32'hFFFF_FFF0, '0, '0, '0);
    send_item(ACT_CHECK, 32'h0000_0010, '0, '0, '0);
    send_item(ACT_CHECK, 32'h0000_0011, '0, '0, '0);
    send_item(ACT_ADD, 32'h0000_0000, 16'h5A5A, 16'h0000, 32'sh0000_0001);
    send_item(ACT_CHECK, 32'h8000_0000, '0, '0, '0);
    send_item(ACT_CHECK, 32'h7FFF_FFFF, '0, '0, '0);
    send_item(ACT_CHECK, 32'h7FFF_FFFF, '0, '0, '0);
    write_interval(16'hFFFF);
    send_item(ACT_CHECK, last_scan_time + 32'h0000_FFFF, '0, '0, '0);
    send_item(ACT_CHECK, last_scan_time + 32'h0001_0000, '0, '0, '0);
  endtask

  // Fills the table while the receiver holds off, then cancels a full owner
  // and fires a whole table in one check.
  task automatic test_table_full();
    logic [OWNER_W-1:0] holder;
    logic [TIME_W-1:0]  base;
    int                 free_slots;
    holder = OWNER_W'($urandom_range(0, 65535));
    base = last_scan_time + 32'd50000;
    free_slots = count_free_slots();
    holdoff_left = 300;
    repeat (free_slots + 1) begin
      send_item(ACT_ADD, base, holder, DELAY_W'($urandom_range(0, 3)), $urandom);
    end
    wait_for_drain();
    send_item(ACT_CANCEL, base, holder, '0, '0);
    free_slots = count_free_slots();
    repeat (free_slots + 1) begin
      send_item(ACT_ADD, base, OWNER_W'($urandom_range(0, 65535)),
                DELAY_W'($urandom_range(0, 3)), $urandom);
    end
    send_item(ACT_CHECK, base + 32'd100000, '0, '0, '0);
  endtask

  // Random mix of well-formed traffic over a few owners, with time jumps and
  // the occasional unused action code.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input logic [IVL_W-1:0] interval, input int n_items);
    logic [OWNER_W-1:0] owner_pool [4];
    logic [ACT_W-1:0]   action;
    logic [OWNER_W-1:0] owner;
    logic [DELAY_W-1:0] delay;
    int                 counted;
    int                 roll;
    write_interval(interval);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    foreach (owner_pool[i]) owner_pool[i] = OWNER_W'($urandom_range(0, 65535));
    sim_now = $urandom;
    counted = 0;
    while (counted < n_items) begin
      roll = $urandom_range(99);
      if (roll < 3) sim_now = $urandom;
      else if (roll < 8) sim_now = sim_now + $urandom_range(60000, 70000);
      else sim_now = sim_now + $urandom_range(0, 12);
      roll = $urandom_range(99);
      if (roll < 40) action = ACT_ADD;
      else if (roll < 75) action = ACT_CHECK;
      else if (roll < 95) action = ACT_CANCEL;
      else action = ACT_UNUSED;
      if ($urandom_range(99) < 80) owner = owner_pool[2'($urandom_range(0, 3))];
      else owner = OWNER_W'($urandom_range(0, 65535));
      if ($urandom_range(99) < 75) delay = DELAY_W'($urandom_range(0, 30));
      else delay = DELAY_W'($urandom_range(0, 65535));
      send_item(action, sim_now, owner, delay, $urandom);
      if (action != ACT_UNUSED) counted++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_actions();
    test_time_wrap();
    test_table_full();
    test_random_traffic(35, 66, 16'd2, 18);
    test_random_traffic(66, 35, 16'd0, 18);
    test_random_traffic(0, 0, IVL_W'($urandom_range(6, 40)), 18);
    wait_for_drain();
    $display("Sent %0d items and checked %0d results: %0d timers fired,", items_sent,
             results_seen, fired_total);
    $display("%0d adds refused on a full table, %0d checks skipped by the interval.",
             full_total, skipped_total);
    if (errors == 0) begin
      $display("owner_tagged_timer_table_core test passed");
    end else begin
      $display("owner_tagged_timer_table_core test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ottt_pkg.sv
rtl/core/ottt_ctrl.sv
rtl/core/ottt_dp.sv
rtl/core/owner_tagged_timer_table_core.sv
dv/tb.sv
